### hw/rtl/alne_pkg.sv
// Shared types and constants for the advertising local-name extractor.
// No dependencies; imported by alne_parse and adv_local_name_extractor_top.
package alne_pkg;

  // Structure types that carry a local name
  localparam logic [7:0] TYPE_NAME_FULL  = 8'h09;
  localparam logic [7:0] TYPE_NAME_SHORT = 8'h08;

  // Result source codes
  localparam logic [1:0] SRC_PAYLOAD = 2'd0;
  localparam logic [1:0] SRC_DEFAULT = 2'd1;
  localparam logic [1:0] SRC_EMPTY   = 2'd2;

  // Length of the default name text
  localparam int unsigned DEFAULT_LEN = 7;

  // One payload byte transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_last;
    logic [1:0] name_source;
  } out_item_t;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_LEN  = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_SKIP = 5'b00100,
    PH_NAME = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  // What one parsed byte produces
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_BYTE    = 2'd1,
    EV_DEFAULT = 2'd2,
    EV_EMPTY   = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic       last;
  } ev_t;

  // Characters of the default name "Unknown"
  function automatic logic [7:0] default_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h55; // U
      3'd1:    c = 8'h6E; // n
      3'd2:    c = 8'h6B; // k
      3'd3:    c = 8'h6E; // n
      3'd4:    c = 8'h6F; // o
      3'd5:    c = 8'h77; // w
      3'd6:    c = 8'h6E; // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/alne_parse.sv
// Length-type-data walker: holds the parse state and classifies each byte.
// Depends on alne_pkg.
module alne_parse
  import alne_pkg::*;
#(
  parameter int unsigned NAME_MAX = 31
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_item_t item,
  output ev_t      ev
);

  localparam int unsigned NW = $clog2(NAME_MAX + 1);
  localparam logic [7:0] NameMax8 = 8'(NAME_MAX);

  phase_t        phase, phase_next;
  logic [7:0]    skip_left, skip_left_next;
  logic [NW-1:0] name_left, name_left_next;

  logic [NW-1:0] name_cap;
  logic [7:0]    skip_dec;
  logic [NW-1:0] name_dec;
  logic          is_name_type;

  assign is_name_type = (item.payload_byte == TYPE_NAME_FULL) ||
                        (item.payload_byte == TYPE_NAME_SHORT);
  assign name_cap = (skip_left > NameMax8) ? NW'(NAME_MAX) : skip_left[NW-1:0];
  assign skip_dec = (skip_left != 8'd0) ? skip_left - 8'd1 : skip_left;
  assign name_dec = (name_left != '0) ? name_left - NW'(1) : name_left;

  // Decide the next state and the result of the current byte
  always_comb begin
    phase_next     = phase;
    skip_left_next = skip_left;
    name_left_next = name_left;
    ev.kind        = EV_NONE;
    ev.data        = item.payload_byte;
    ev.last        = 1'b0;
    case (phase)
      PH_LEN: begin
        if (item.payload_byte == 8'd0 || item.payload_end) begin
          ev.kind    = EV_DEFAULT;
          phase_next = PH_DONE;
        end else begin
          skip_left_next = item.payload_byte - 8'd1;
          phase_next     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (is_name_type) begin
          if (name_cap == '0 || item.payload_end) begin
            ev.kind    = EV_EMPTY;
            phase_next = PH_DONE;
          end else begin
            name_left_next = name_cap;
            phase_next     = PH_NAME;
          end
        end else if (item.payload_end) begin
          ev.kind    = EV_DEFAULT;
          phase_next = PH_DONE;
        end else begin
          phase_next = (skip_left != 8'd0) ? PH_SKIP : PH_LEN;
        end
      end
      PH_SKIP: begin
        if (item.payload_end) begin
          ev.kind    = EV_DEFAULT;
          phase_next = PH_DONE;
        end else begin
          skip_left_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = PH_LEN;
        end
      end
      PH_NAME: begin
        ev.kind        = EV_BYTE;
        ev.last        = (name_dec == '0) || item.payload_end;
        name_left_next = name_dec;
        if (name_dec == '0) phase_next = PH_DONE;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase
    // Restart the walk after the final byte of a payload
    if (item.payload_end) begin
      phase_next     = PH_LEN;
      skip_left_next = 8'd0;
      name_left_next = '0;
    end
  end

  // Advance the state when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEN;
      skip_left <= 8'd0;
      name_left <= '0;
    end else if (step) begin
      phase     <= phase_next;
      skip_left <= skip_left_next;
      name_left <= name_left_next;
    end
  end

endmodule

### hw/rtl/adv_local_name_extractor_top.sv
// Top level of the advertising local-name extractor: input register,
// parser and result register with the default-name sequencer.
// Depends on alne_pkg and alne_parse.
//
//   channel  | valid          | stall          | data
//   ---------+----------------+----------------+-------------------------
//   payload  | payload_valid  | payload_stall  | payload (in_item_t)
//   result   | result_valid   | result_stall   | result  (out_item_t)
//
// A payload byte is registered in the input and then the result register;
// a byte with no result is consumed every cycle, and one with a result every
// cycle unless a result stall or the default name holds it. The byte that
// calls for the default name "Unknown" is consumed at once, and the result
// register then steps through the other six characters; a byte with a result
// waits in the input register until the last one is loaded, others flow on.
// Reset clears the parse state, both valid flags and the character counter.
// A result stall holds the result register and backs up into payload_stall.
module adv_local_name_extractor_top
  import alne_pkg::*;
#(
  parameter int unsigned NAME_MAX = 31
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      payload_valid,
  output logic      payload_stall,
  input  in_item_t  payload,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic     in_q_valid;
  in_item_t in_q;
  ev_t      ev;
  logic     out_free;
  logic     consume;
  logic [2:0] burst_left;
  logic [2:0] burst_idx;

  assign out_free      = !result_valid || !result_stall;
  assign consume       = in_q_valid &&
                         (ev.kind == EV_NONE || (out_free && burst_left == 3'd0));
  assign payload_stall = in_q_valid && !consume;
  assign burst_idx     = 3'(DEFAULT_LEN) - burst_left;

  // Hold the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!payload_stall) begin
      in_q_valid <= payload_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!payload_stall) begin
      in_q <= payload;
    end
  end

  alne_parse #(
    .NAME_MAX(NAME_MAX)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (consume),
    .item (in_q),
    .ev   (ev)
  );

  // Load the result register: default text first, then new events
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      burst_left   <= 3'd0;
    end else if (out_free) begin
      if (burst_left != 3'd0) begin
        result_valid <= 1'b1;
        burst_left   <= burst_left - 3'd1;
      end else if (consume && ev.kind != EV_NONE) begin
        result_valid <= 1'b1;
        burst_left   <= (ev.kind == EV_DEFAULT) ? 3'(DEFAULT_LEN - 1) : 3'd0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (burst_left != 3'd0) begin
        result.name_byte   <= default_char(burst_idx);
        result.name_last   <= (burst_left == 3'd1);
        result.name_source <= SRC_DEFAULT;
      end else begin
        case (ev.kind)
          EV_BYTE: begin
            result.name_byte   <= ev.data;
            result.name_last   <= ev.last;
            result.name_source <= SRC_PAYLOAD;
          end
          EV_DEFAULT: begin
            result.name_byte   <= default_char(3'd0);
            result.name_last   <= 1'b0;
            result.name_source <= SRC_DEFAULT;
          end
          EV_EMPTY: begin
            result.name_byte   <= 8'd0;
            result.name_last   <= 1'b1;
            result.name_source <= SRC_EMPTY;
          end
          default: begin
            result <= result;
          end
        endcase
      end
    end
  end

endmodule
